// ===== src/arc_pkg.sv =====
// ---------------------------------------------------------------------------
// ARP responder cache package
// Request and result layouts, the token that travels the cell chain, and
// the protocol constants shared by the cache cells and the top level.
// ---------------------------------------------------------------------------
package arc_pkg;

  // Default number of cache entries.
  localparam int unsigned CACHE_ENTRIES_DEF = 16;

  // Configuration port geometry and register indexes.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IPV4 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC  = 1'd1;

  // Request kinds.
  localparam logic OP_HEADER  = 1'b0;
  localparam logic OP_RESOLVE = 1'b1;

  // ARP header codes.
  localparam logic [15:0] OPER_REQUEST = 16'd1;
  localparam logic [15:0] OPER_REPLY   = 16'd2;
  localparam logic [15:0] PTYPE_IPV4   = 16'h0800;

  // All-ones Ethernet broadcast address.
  localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

  // One incoming request.
  typedef struct packed {
    logic        opcode;
    logic [15:0] arp_oper;
    logic [15:0] proto_type;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [31:0] target_ip;
  } arc_in_t;

  // One result.
  typedef struct packed {
    logic        send_packet;
    logic        send_is_reply;
    logic [47:0] dest_mac;
    logic [47:0] frame_target_mac;
    logic [31:0] frame_target_ip;
    logic        lookup_hit;
    logic [47:0] lookup_mac;
    logic        insert_dropped;
  } arc_out_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic        active;
    logic [31:0] ip;
    logic        found;
    logic [47:0] mac;
  } arc_tok_t;

endpackage

// ===== src/arc_cell.sv =====
// ---------------------------------------------------------------------------
// ARP cache cell
// Holds one IP/MAC entry, compares a passing search token against it and
// hands the token on to the next cell in the cycle after.
// ---------------------------------------------------------------------------
module arc_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  arc_pkg::arc_tok_t tok_in,
  input  logic             wr_en,
  input  logic [31:0]      wr_ip,
  input  logic [47:0]      wr_mac,
  output arc_pkg::arc_tok_t tok_out
);
  import arc_pkg::*;

  logic        valid_r;
  logic [31:0] ip_r;
  logic [47:0] mac_r;
  arc_tok_t    tok_r;
  arc_tok_t    tok_nxt;
  logic        match;

  // Entry storage; only the valid bit is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_en) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ip_r  <= wr_ip;
      mac_r <= wr_mac;
    end
  end

  // Compare the token with this entry; the first match along the chain wins.
  assign match = valid_r && (ip_r == tok_in.ip);

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.active && match && !tok_in.found) begin
      tok_nxt.found = 1'b1;
      tok_nxt.mac   = mac_r;
    end
  end

  // Hand the token to the neighbor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.active <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== src/arp_responder_cache_unit.sv =====
// ---------------------------------------------------------------------------
// ARP responder with learning cache
// Top level: request/result handshakes, configuration registers, the row
// of cache cells and the decision and learning logic at the end of the row.
// ---------------------------------------------------------------------------
// A request is either a received ARP header or a resolve of an IPv4 address.
// Its search token walks a row of CACHE_ENTRIES cells, one cell per cycle,
// into a hold register, from which the result is written to the output
// register. A new request is taken once the previous result has been
// written to the output register, so requests do not overlap; a result
// waiting in the output register delays the held result and the next request.
// Senders of IPv4 requests and replies are learned into the next free cell
// when absent; entries are never evicted, and a learn into a full cache is
// dropped and flagged. A request aimed at own_ipv4 yields a reply frame, a
// resolve miss yields a broadcast request frame. Configuration is to be
// written only while no request is in flight; the block does not enforce
// this. There is no clearing pass after reset.
module arp_responder_cache_unit #(
  parameter int unsigned CACHE_ENTRIES = arc_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  arc_pkg::arc_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output arc_pkg::arc_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [arc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import arc_pkg::*;

  localparam int unsigned CNT_W = $clog2(CACHE_ENTRIES + 1);

  logic [31:0]       own_ipv4_r;
  logic [47:0]       own_mac_r;
  logic              busy_r;
  arc_in_t           item_r;
  arc_tok_t          hold_r;
  logic              hold_v_r;
  logic [CNT_W-1:0]  fill_r;
  logic              out_valid_r;
  arc_out_t          out_r;
  arc_out_t          res_nxt;
  logic              learn_wr;
  logic              in_acc;
  logic              emit;
  arc_tok_t          head_tok;
  arc_tok_t          chain_tok [CACHE_ENTRIES+1];
  logic [CACHE_ENTRIES-1:0] tok_act;

  // Configuration registers; own_mac is stored here, but no output of this
  // block carries it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ipv4_r <= '0;
      own_mac_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OWN_IPV4: own_ipv4_r <= cfg_wdata[31:0];
        REG_OWN_MAC:  own_mac_r  <= cfg_wdata[47:0];
        default: ;
      endcase
    end
  end

  // Request acceptance and the token injected into the first cell.
  assign in_ready = !busy_r;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    head_tok.active = in_acc;
    head_tok.ip     = (in_data.opcode == OP_RESOLVE) ? in_data.target_ip
                                                     : in_data.sender_ip;
    head_tok.found  = 1'b0;
    head_tok.mac    = '0;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
  end

  // Row of cache cells.
  assign chain_tok[0] = head_tok;

  for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
    arc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (chain_tok[i]),
      .wr_en   (learn_wr && (fill_r == CNT_W'(i))),
      .wr_ip   (item_r.sender_ip),
      .wr_mac  (item_r.sender_mac),
      .tok_out (chain_tok[i+1])
    );
    assign tok_act[i] = chain_tok[i+1].active;
  end

  // Catch the token leaving the last cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (chain_tok[CACHE_ENTRIES].active) begin
      hold_v_r <= 1'b1;
    end else if (emit) begin
      hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chain_tok[CACHE_ENTRIES].active) begin
      hold_r <= chain_tok[CACHE_ENTRIES];
    end
  end

  assign emit = hold_v_r && (!out_valid_r || out_ready);

  // Result and learning decision.
  always_comb begin
    res_nxt  = '0;
    learn_wr = 1'b0;
    if (item_r.opcode == OP_HEADER) begin
      if ((item_r.proto_type == PTYPE_IPV4) &&
          ((item_r.arp_oper == OPER_REQUEST) || (item_r.arp_oper == OPER_REPLY))) begin
        if (!hold_r.found) begin
          if (fill_r == CNT_W'(CACHE_ENTRIES)) begin
            res_nxt.insert_dropped = 1'b1;
          end else begin
            learn_wr = emit;
          end
        end
        if ((item_r.arp_oper == OPER_REQUEST) && (item_r.target_ip == own_ipv4_r)) begin
          res_nxt.send_packet      = 1'b1;
          res_nxt.send_is_reply    = 1'b1;
          res_nxt.dest_mac         = item_r.sender_mac;
          res_nxt.frame_target_mac = item_r.sender_mac;
          res_nxt.frame_target_ip  = item_r.sender_ip;
        end
      end
    end else begin
      if (hold_r.found) begin
        res_nxt.lookup_hit = 1'b1;
        res_nxt.lookup_mac = hold_r.mac;
      end else begin
        res_nxt.send_packet     = 1'b1;
        res_nxt.send_is_reply   = 1'b0;
        res_nxt.dest_mac        = MAC_BCAST;
        res_nxt.frame_target_ip = item_r.target_ip;
      end
    end
  end

  // Fill count and busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      busy_r <= 1'b0;
    end else begin
      if (learn_wr) begin
        fill_r <= fill_r + CNT_W'(1);
      end
      if (in_acc) begin
        busy_r <= 1'b1;
      end else if (emit) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CACHE_ENTRIES))
    else $error("fill count beyond cache size");

  a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r |-> busy_r)
    else $error("held token without a request in flight");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({tok_act, hold_v_r}) <= 1)
    else $error("more than one token in the cell row");

  a_result_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $fell(busy_r))
    else $error("result appeared without finishing a request");

endmodule

// ===== tb/sv/tb_arp_responder_cache_unit.sv =====
// ---------------------------------------------------------------------------
// Testbench for the ARP responder with learning cache
// Drives received ARP headers and resolve requests through the valid/ready
// request channel, mirrors the cache and the interface registers, and checks
// every result field against the mirror's prediction, in request order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_arp_responder_cache_unit;
  import arc_pkg::*;

  localparam int unsigned ENTRIES     = CACHE_ENTRIES_DEF;
  localparam int unsigned POOL_SIZE   = 40;
  localparam int unsigned RUN_ITEMS   = 566;
  localparam int unsigned BURST_ITEMS = 40;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned END_WAIT    = 2 * (ENTRIES + 2);
  localparam int unsigned STALL_LIMIT = 5000;

  // Mirror of the cache and registers; predicts one answer per request.
  class arp_cache_mirror;
    logic [31:0] own_ip;
    logic [47:0] own_mac;
    bit          slot_used[ENTRIES];
    logic [31:0] slot_ip[ENTRIES];
    logic [47:0] slot_mac[ENTRIES];
    int unsigned slots_filled;
    arc_out_t    due_answers[$];
    int unsigned errors;

    function new();
      own_ip       = '0;
      own_mac      = '0;
      slots_filled = 0;
      errors       = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_OWN_IPV4) begin
        own_ip = data[31:0];
      end else if (idx == REG_OWN_MAC) begin
        own_mac = data;
      end
    endfunction

    function int find_slot(logic [31:0] ip);
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_used[i] && slot_ip[i] == ip) return i;
      end
      return -1;
    endfunction

    // Update the mirror for an accepted request and queue its answer.
    function void note_request(arc_in_t req);
      arc_out_t ans;
      int       slot;
      ans = '0;
      if (req.opcode == OP_HEADER) begin
        if (req.proto_type == PTYPE_IPV4 &&
            (req.arp_oper == OPER_REQUEST || req.arp_oper == OPER_REPLY)) begin
          // Learn the sender unless it is known; a full cache drops it.
          if (find_slot(req.sender_ip) < 0) begin
            if (slots_filled >= ENTRIES) begin
              ans.insert_dropped = 1'b1;
            end else begin
              slot_used[slots_filled] = 1'b1;
              slot_ip[slots_filled]   = req.sender_ip;
              slot_mac[slots_filled]  = req.sender_mac;
              slots_filled++;
            end
          end
          // A request for our address is answered with a reply frame.
          if (req.arp_oper == OPER_REQUEST && req.target_ip == own_ip) begin
            ans.send_packet      = 1'b1;
            ans.send_is_reply    = 1'b1;
            ans.dest_mac         = req.sender_mac;
            ans.frame_target_mac = req.sender_mac;
            ans.frame_target_ip  = req.sender_ip;
          end
        end
      end else begin
        slot = find_slot(req.target_ip);
        if (slot >= 0) begin
          ans.lookup_hit = 1'b1;
          ans.lookup_mac = slot_mac[slot];
        end else begin
          // A miss asks the whole segment for the address.
          ans.send_packet     = 1'b1;
          ans.dest_mac        = MAC_BCAST;
          ans.frame_target_ip = req.target_ip;
        end
      end
      due_answers.push_back(ans);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    // Compare one accepted result with the oldest answer still due.
    function void check_answer(arc_out_t got);
      arc_out_t want;
      if (due_answers.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending: expected none, actual %h",
                 $time, got);
      end else begin
        want = due_answers.pop_front();
        compare_field("send_packet", 64'(want.send_packet), 64'(got.send_packet));
        compare_field("send_is_reply", 64'(want.send_is_reply), 64'(got.send_is_reply));
        compare_field("dest_mac", 64'(want.dest_mac), 64'(got.dest_mac));
        compare_field("frame_target_mac", 64'(want.frame_target_mac),
                      64'(got.frame_target_mac));
        compare_field("frame_target_ip", 64'(want.frame_target_ip),
                      64'(got.frame_target_ip));
        compare_field("lookup_hit", 64'(want.lookup_hit), 64'(got.lookup_hit));
        compare_field("lookup_mac", 64'(want.lookup_mac), 64'(got.lookup_mac));
        compare_field("insert_dropped", 64'(want.insert_dropped), 64'(got.insert_dropped));
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  arc_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  arc_out_t              out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  arp_cache_mirror mirror = new();

  logic [31:0] ip_pool[POOL_SIZE];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_ticket   = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  arp_responder_cache_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: a long hold when one is asked for, random stalls otherwise.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_ticket != hold_served) begin
      hold_served = hold_ticket;
      hold_left   = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Check every accepted result.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      mirror.check_answer(out_data);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic [47:0] rand_mac();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic logic [31:0] pool_ip();
    return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic arc_in_t make_header(logic [15:0] oper, logic [15:0] ptype,
                                          logic [31:0] sip, logic [47:0] smac,
                                          logic [31:0] tip);
    arc_in_t req;
    req.opcode     = OP_HEADER;
    req.arp_oper   = oper;
    req.proto_type = ptype;
    req.sender_ip  = sip;
    req.sender_mac = smac;
    req.target_ip  = tip;
    return req;
  endfunction

  function automatic arc_in_t make_resolve(logic [31:0] tip);
    arc_in_t req;
    req.opcode     = OP_RESOLVE;
    req.arp_oper   = 16'($urandom);
    req.proto_type = 16'($urandom);
    req.sender_ip  = $urandom;
    req.sender_mac = rand_mac();
    req.target_ip  = tip;
    return req;
  endfunction

  // Mostly well-formed traffic around a small address pool, some noise.
  function automatic arc_in_t make_random_request();
    arc_in_t     req;
    int unsigned pick;
    req.opcode     = 1'($urandom_range(0, 1));
    req.arp_oper   = 16'($urandom);
    req.proto_type = 16'($urandom);
    req.sender_ip  = $urandom;
    req.sender_mac = rand_mac();
    req.target_ip  = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      req.opcode     = OP_HEADER;
      req.proto_type = PTYPE_IPV4;
      req.arp_oper   = (pick < 35) ? OPER_REQUEST : OPER_REPLY;
      if ($urandom_range(0, 9) != 0) req.sender_ip = pool_ip();
      req.target_ip = ($urandom_range(0, 1) == 1) ? mirror.own_ip : pool_ip();
    end else if (pick < 88) begin
      req.opcode = OP_RESOLVE;
      if ($urandom_range(0, 3) != 0) req.target_ip = pool_ip();
    end
    return req;
  endfunction

  // Offer one request after random idle cycles; returns at the next falling edge.
  task automatic send_request(input arc_in_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mirror.note_request(req);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted answer has come back.
  task automatic drain_answers();
    in_valid <= 1'b0;
    @(negedge clk);
    while (mirror.due_answers.size() != 0) @(negedge clk);
  endtask

  // Write both interface registers while the block is idle.
  task automatic configure(input logic [CFG_DATA_W-1:0] ip_word,
                           input logic [CFG_DATA_W-1:0] mac_word);
    cfg_we    <= 1'b1;
    cfg_index <= REG_OWN_IPV4;
    cfg_wdata <= ip_word;
    mirror.write_reg(REG_OWN_IPV4, ip_word);
    @(negedge clk);
    cfg_index <= REG_OWN_MAC;
    cfg_wdata <= mac_word;
    mirror.write_reg(REG_OWN_MAC, mac_word);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : main_seq
    int unsigned n;
    int unsigned phase;
    logic [31:0] some_ip;
    for (n = 0; n < POOL_SIZE; n++) ip_pool[n] = $urandom;
    some_ip = $urandom;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, all-ones interface address with stray upper data bits.
    configure('1, '1);
    send_request(make_resolve(32'h0000_0000));
    send_request(make_resolve(32'hFFFF_FFFF));
    send_request(make_header(OPER_REQUEST, PTYPE_IPV4, 32'h0, 48'h0, 32'hFFFF_FFFF));
    send_request(make_header(OPER_REPLY, PTYPE_IPV4, 32'hFFFF_FFFF, '1, 32'h0));
    send_request(make_resolve(32'h0000_0000));
    send_request(make_resolve(32'hFFFF_FFFF));
    // A known sender with a new MAC is neither updated nor dropped.
    send_request(make_header(OPER_REQUEST, PTYPE_IPV4, 32'h0, rand_mac(), 32'hFFFF_FFFF));
    send_request(make_resolve(32'h0000_0000));
    // Other operations and protocols are ignored.
    send_request(make_header(16'd0, PTYPE_IPV4, some_ip, rand_mac(), 32'hFFFF_FFFF));
    send_request(make_header(16'd3, PTYPE_IPV4, some_ip, rand_mac(), 32'hFFFF_FFFF));
    send_request(make_header('1, '1, some_ip, rand_mac(), 32'hFFFF_FFFF));
    send_request(make_header(OPER_REQUEST, 16'h86DD, some_ip, rand_mac(), 32'hFFFF_FFFF));
    send_request(make_header(OPER_REQUEST, 16'h0000, some_ip, rand_mac(), 32'hFFFF_FFFF));
    send_request(make_resolve(some_ip));
    // Learns without a reply: foreign target, and a reply aimed at us.
    send_request(make_header(OPER_REQUEST, PTYPE_IPV4, some_ip, rand_mac(), 32'h0));
    send_request(make_header(OPER_REPLY, PTYPE_IPV4, pool_ip(), rand_mac(), 32'hFFFF_FFFF));
    send_request(make_resolve(some_ip));
    drain_answers();

    // Back-pressure: the result side holds off while requests keep coming.
    hold_ticket++;
    for (n = 0; n < BURST_ITEMS; n++) send_request(make_random_request());
    drain_answers();

    // Random phases with different idling and register settings.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 67;
          configure({16'hFFFF, 32'h0}, '0);
        end
        1: begin
          send_idle_pct = 67;
          recv_idle_pct = 29;
          configure({16'($urandom), pool_ip()}, rand_mac());
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          configure({16'h0, pool_ip()}, '1);
        end
      endcase
      for (n = 0; n < RUN_ITEMS; n++) send_request(make_random_request());
      drain_answers();
    end

    repeat (END_WAIT) @(negedge clk);
    if (mirror.errors == 0 && mirror.due_answers.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/arc_pkg.sv
src/arc_cell.sv
src/arp_responder_cache_unit.sv
tb/sv/tb_arp_responder_cache_unit.sv
